// File: design/wildcard_byte_pattern_scan_top_assert.svh
// Assertion macros for the wildcard byte pattern scanner.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_TOP_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WBPS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// Next-cycle implication, disabled during reset.
`define WBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

// File: design/wbps_pkg.sv
// Shared constants, register indexes and types of the byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int COUNT_BITS    = 32;
    localparam int ADDR_BITS     = 48;
    localparam int LEN_BITS      = 5;
    localparam int PAT_IDX_BITS  = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_ADDRESS   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_ONLY     = 3'd5;

    typedef struct packed {
        logic [MAX_PATTERN*8-1:0] pattern;
        logic [MAX_PATTERN-1:0]   care_mask;
        logic [LEN_BITS-1:0]      pattern_length;
        logic [ADDR_BITS-1:0]     base_address;
        logic                     first_only;
    } cfg_t;

    // One classified byte that produces a result.
    typedef struct packed {
        logic [COUNT_BITS-1:0] offset;
        logic                  hit;
        logic                  last;
        logic                  any_found;
    } event_t;

endpackage

// File: design/wildcard_byte_pattern_scan_top.sv
// Top level of the wildcard byte pattern scanner: config registers, front, queue, back.
`timescale 1ns / 1ps
//
// Scans a byte stream for a signature of up to 16 bytes with per-byte care bits.
// Input channel (s_valid/s_ready): one byte per transfer, s_last_byte on the final
// byte of a region. Result channel (m_valid/m_ready): one transfer per byte that is a
// hit or the last byte (end of scan, with any_found); other bytes give no result.
// Config channel (cfg_valid/cfg_ready): cfg_index selects pattern_low, pattern_high,
// care_mask, pattern_length, base_address, first_only; cfg_ready is always high and
// writes are expected only while the scanner is idle. Unknown indexes are dropped.
// Throughput: one byte per cycle while the queue has room; window shift and masked
// compare finish in the cycle the byte is taken. The front classifies the byte into
// the queue at the transfer edge; the back adds the base address when it pops the
// queue head into the output register, which drives m_valid.
// A two-entry queue sits between front and back. When the receiver stalls, the
// output register holds, the queue fills, and s_ready drops once it is full.
// Reset (aresetn low, synchronous) restores the config defaults, clears the window,
// byte count, found flag, queue and output valid.
//

`include "wildcard_byte_pattern_scan_top_assert.svh"

module wildcard_byte_pattern_scan_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // byte input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_last_byte,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [wbps_pkg::ADDR_BITS-1:0]       m_match_address,
    output logic                                 m_hit,
    output logic                                 m_end_of_scan,
    output logic                                 m_any_found
);

    logic [63:0]                          pat_low_reg;
    logic [63:0]                          pat_high_reg;
    logic [wbps_pkg::MAX_PATTERN-1:0]     care_reg;
    logic [wbps_pkg::LEN_BITS-1:0]        len_reg;
    logic [wbps_pkg::ADDR_BITS-1:0]       base_reg;
    logic                                 first_only_reg;
    wbps_pkg::cfg_t                       cfg;

    logic                                 evt_push;
    wbps_pkg::event_t                     evt;
    wbps_pkg::event_t                     head_evt;
    logic                                 q_not_empty;
    logic                                 q_full;
    logic                                 q_pop;

    assign cfg_ready = 1'b1;

    // Register file; each write keeps only the register's own width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            care_reg       <= '1;
            len_reg        <= wbps_pkg::LEN_BITS'(1);
            base_reg       <= '0;
            first_only_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wbps_pkg::REG_PATTERN_LOW: begin
                    pat_low_reg <= cfg_data;
                end
                wbps_pkg::REG_PATTERN_HIGH: begin
                    pat_high_reg <= cfg_data;
                end
                wbps_pkg::REG_CARE_MASK: begin
                    care_reg <= cfg_data[wbps_pkg::MAX_PATTERN-1:0];
                end
                wbps_pkg::REG_PATTERN_LENGTH: begin
                    len_reg <= cfg_data[wbps_pkg::LEN_BITS-1:0];
                end
                wbps_pkg::REG_BASE_ADDRESS: begin
                    base_reg <= cfg_data[wbps_pkg::ADDR_BITS-1:0];
                end
                wbps_pkg::REG_FIRST_ONLY: begin
                    first_only_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.pattern        = {pat_high_reg, pat_low_reg};
    assign cfg.care_mask      = care_reg;
    assign cfg.pattern_length = len_reg;
    assign cfg.base_address   = base_reg;
    assign cfg.first_only     = first_only_reg;

    // Input is taken whenever the queue has room.
    assign s_ready = !q_full;

    wbps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .evt_push  (evt_push),
        .evt       (evt)
    );

    wbps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_push),
        .push_evt  (evt),
        .pop       (q_pop),
        .head_evt  (head_evt),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    wbps_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .base_address  (base_reg),
        .head_evt      (head_evt),
        .head_valid    (q_not_empty),
        .pop           (q_pop),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .match_address (m_match_address),
        .hit           (m_hit),
        .end_of_scan   (m_end_of_scan),
        .any_found     (m_any_found)
    );

    // A result that is not a hit carries a zero address.
    `WBPS_ASSERT_IMPLY(a_nohit_addr_zero, aclk, aresetn, m_valid && !m_hit, m_match_address == '0)
    // any_found is only raised at end of scan, and always when that result is a hit.
    `WBPS_ASSERT_IMPLY(a_any_only_eos, aclk, aresetn, m_valid && !m_end_of_scan, !m_any_found)
    `WBPS_ASSERT_IMPLY(a_hit_eos_any, aclk, aresetn, m_valid && m_hit && m_end_of_scan, m_any_found)
    // Stalled output with a full queue must keep the input closed.
    `WBPS_ASSERT_NEXT(a_full_blocks, aclk, aresetn, q_full && m_valid && !m_ready && !q_pop, !s_ready)

endmodule

// File: design/wbps_front.sv
// Front end: byte window, region counter, masked compare and hit classification.
`timescale 1ns / 1ps

module wbps_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wbps_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   evt_push,
    output wbps_pkg::event_t       evt
);

    logic [7:0]                        win_reg   [wbps_pkg::MAX_PATTERN];
    logic [7:0]                        win_shift [wbps_pkg::MAX_PATTERN];
    logic [wbps_pkg::COUNT_BITS-1:0]   seen_reg;
    logic [wbps_pkg::COUNT_BITS-1:0]   seen_next;
    logic                              found_reg;
    logic [wbps_pkg::LEN_BITS-1:0]     len_eff;
    logic                              match;
    logic                              full_window;
    logic                              hit;
    logic                              accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        len_eff = cfg.pattern_length;
        if (cfg.pattern_length == '0) begin
            len_eff = wbps_pkg::LEN_BITS'(1);
        end else if (cfg.pattern_length > wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN)) begin
            len_eff = wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN);
        end
    end

    always_comb begin
        win_shift[0] = data_byte;
        for (int i = 1; i < wbps_pkg::MAX_PATTERN; i++) begin
            win_shift[i] = win_reg[i-1];
        end
    end

    assign seen_next = (seen_reg == wbps_pkg::COUNT_MAX) ? seen_reg
                                                         : seen_reg + 1'b1;

    // Window slot p holds signature byte len-1-p.
    always_comb begin
        logic [wbps_pkg::LEN_BITS-1:0]     pos;
        logic [wbps_pkg::LEN_BITS-1:0]     k;
        logic [wbps_pkg::PAT_IDX_BITS-1:0] ki;
        match = 1'b1;
        for (int p = 0; p < wbps_pkg::MAX_PATTERN; p++) begin
            pos = wbps_pkg::LEN_BITS'(p);
            k   = len_eff - wbps_pkg::LEN_BITS'(1) - pos;
            ki  = k[wbps_pkg::PAT_IDX_BITS-1:0];
            if (pos < len_eff && cfg.care_mask[ki]
                    && win_shift[p] != cfg.pattern[{ki, 3'b000} +: 8]) begin
                match = 1'b0;
            end
        end
    end

    assign full_window = seen_next >= wbps_pkg::COUNT_BITS'(len_eff);
    assign hit         = full_window && match && !(cfg.first_only && found_reg);

    assign evt_push      = accept && (hit || last_byte);
    assign evt.offset    = seen_next - wbps_pkg::COUNT_BITS'(len_eff);
    assign evt.hit       = hit;
    assign evt.last      = last_byte;
    assign evt.any_found = last_byte && (found_reg || hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            found_reg <= 1'b0;
            for (int i = 0; i < wbps_pkg::MAX_PATTERN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (accept) begin
            if (last_byte) begin
                seen_reg  <= '0;
                found_reg <= 1'b0;
                for (int i = 0; i < wbps_pkg::MAX_PATTERN; i++) begin
                    win_reg[i] <= '0;
                end
            end else begin
                seen_reg  <= seen_next;
                found_reg <= found_reg || hit;
                for (int i = 0; i < wbps_pkg::MAX_PATTERN; i++) begin
                    win_reg[i] <= win_shift[i];
                end
            end
        end
    end

endmodule

// File: design/wbps_queue.sv
// Short event queue between front and back end.
`timescale 1ns / 1ps

module wbps_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  wbps_pkg::event_t     push_evt,
    input  logic                 pop,
    output wbps_pkg::event_t     head_evt,
    output logic                 not_empty,
    output logic                 full
);

    wbps_pkg::event_t                 mem [wbps_pkg::QUEUE_DEPTH];
    logic [wbps_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [wbps_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [wbps_pkg::QCNT_BITS-1:0]   count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full      = count_reg == wbps_pkg::QCNT_BITS'(wbps_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_evt  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == wbps_pkg::QPTR_BITS'(wbps_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == wbps_pkg::QPTR_BITS'(wbps_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/wbps_back.sv
// Back end: match address add and registered result output.
`timescale 1ns / 1ps

module wbps_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [wbps_pkg::ADDR_BITS-1:0]   base_address,
    input  wbps_pkg::event_t                 head_evt,
    input  logic                             head_valid,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [wbps_pkg::ADDR_BITS-1:0]   match_address,
    output logic                             hit,
    output logic                             end_of_scan,
    output logic                             any_found
);

    logic                             valid_reg;
    logic [wbps_pkg::ADDR_BITS-1:0]   addr_reg;
    logic [wbps_pkg::ADDR_BITS-1:0]   addr_next;
    logic                             hit_reg;
    logic                             eos_reg;
    logic                             any_reg;

    assign pop       = head_valid && (!valid_reg || out_ready);
    assign addr_next = head_evt.hit
                       ? base_address + wbps_pkg::ADDR_BITS'(head_evt.offset)
                       : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            addr_reg <= addr_next;
            hit_reg  <= head_evt.hit;
            eos_reg  <= head_evt.last;
            any_reg  <= head_evt.any_found;
        end
    end

    assign out_valid     = valid_reg;
    assign match_address = addr_reg;
    assign hit           = hit_reg;
    assign end_of_scan   = eos_reg;
    assign any_found     = any_reg;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the wildcard byte pattern scanner top level.
`timescale 1ns / 1ps

module testbench;

    // Indexes past the last register: writes there must be dropped.
    localparam logic [wbps_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [wbps_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    // One scan report as it leaves the result channel.
    typedef struct packed {
        logic [wbps_pkg::ADDR_BITS-1:0] match_address;
        logic                           hit;
        logic                           end_of_scan;
        logic                           any_found;
    } scan_result_t;

    // Directed rows: a register write, a byte checked by the predictor, a byte that
    // must give no report, or a byte whose report is written out by hand.
    typedef enum logic [1:0] {ROW_REG, ROW_PREDICT, ROW_QUIET, ROW_FIXED} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [wbps_pkg::CFG_IDX_BITS-1:0]  reg_index;
        logic [wbps_pkg::CFG_DATA_BITS-1:0] reg_value;
        logic [7:0]                         data_byte;
        logic                               last_byte;
        scan_result_t                       report;
    } stim_row_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [wbps_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [wbps_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic                               s_valid;
    logic                               s_ready;
    logic [7:0]                         s_data_byte;
    logic                               s_last_byte;
    logic                               m_valid;
    logic                               m_ready;
    logic [wbps_pkg::ADDR_BITS-1:0]     m_match_address;
    logic                               m_hit;
    logic                               m_end_of_scan;
    logic                               m_any_found;

    wildcard_byte_pattern_scan_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_address (m_match_address),
        .m_hit           (m_hit),
        .m_end_of_scan   (m_end_of_scan),
        .m_any_found     (m_any_found)
    );

    // Shadow copy of the register file.
    logic [63:0]                     sig_lo;
    logic [63:0]                     sig_hi;
    logic [15:0]                     sig_care;
    logic [wbps_pkg::LEN_BITS-1:0]   sig_len;
    logic [wbps_pkg::ADDR_BITS-1:0]  sig_base;
    logic                            sig_first_only;

    // Shadow copy of the scan state: window (entry 0 newest), byte count, hit flag.
    logic [7:0]                      win_bytes [wbps_pkg::MAX_PATTERN];
    logic [wbps_pkg::COUNT_BITS-1:0] region_count;
    logic                            region_found;

    scan_result_t pending_reports [$];
    stim_row_t    directed_rows [$];

    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned fail_count;
    int unsigned bytes_sent;
    int unsigned regions_sent;
    int unsigned reports_checked;
    int unsigned hits_checked;
    int unsigned settings_used;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("wildcard_byte_pattern_scan_top regression: fail");
        $finish;
    end

    // Signature length as the scanner uses it: 0 counts as 1, clamp at the window size.
    function automatic int unsigned active_len();
        if (sig_len == 0) begin
            return 1;
        end
        if (sig_len > wbps_pkg::MAX_PATTERN) begin
            return wbps_pkg::MAX_PATTERN;
        end
        return sig_len;
    endfunction

    function automatic logic [7:0] sig_byte(input int unsigned k);
        logic [127:0] sig;
        sig = {sig_hi, sig_lo};
        return sig[8*k +: 8];
    endfunction

    function automatic void clear_region();
        foreach (win_bytes[i]) begin
            win_bytes[i] = 8'h00;
        end
        region_count = '0;
        region_found = 1'b0;
    endfunction

    // Expected reports are kept in arrival order.
    function automatic void append_report(input scan_result_t rep);
        pending_reports = {pending_reports, rep};
    endfunction

    function automatic void append_row(input stim_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    // Advance the shadow scan by one byte; returns 1 when the byte yields a report.
    function automatic bit predict_scan(input logic [7:0] b, input logic last,
                                        output scan_result_t r);
        int unsigned n;
        bit          match;
        bit          hit;
        n = active_len();
        hit = 1'b0;
        for (int i = wbps_pkg::MAX_PATTERN - 1; i > 0; i--) begin
            win_bytes[i] = win_bytes[i-1];
        end
        win_bytes[0] = b;
        if (region_count != wbps_pkg::COUNT_MAX) begin
            region_count++;
        end
        r = '0;
        // Compare only once the whole window lies inside the region.
        if (region_count >= n) begin
            match = 1'b1;
            for (int unsigned k = 0; k < n; k++) begin
                if (sig_care[k] && win_bytes[n-1-k] != sig_byte(k)) begin
                    match = 1'b0;
                end
            end
            if (match && !(sig_first_only && region_found)) begin
                hit = 1'b1;
                r.match_address = sig_base + (region_count - n);
                region_found = 1'b1;
            end
        end
        r.hit = hit;
        r.end_of_scan = last;
        r.any_found = last && region_found;
        if (last) begin
            clear_region();
        end
        return hit || last;
    endfunction

    function automatic stim_row_t reg_row(input logic [wbps_pkg::CFG_IDX_BITS-1:0] idx,
                                          input logic [wbps_pkg::CFG_DATA_BITS-1:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic stim_row_t byte_row(input row_kind_t kind, input logic [7:0] b,
                                           input logic last, input scan_result_t rep);
        stim_row_t row;
        row = '0;
        row.kind = kind;
        row.data_byte = b;
        row.last_byte = last;
        row.report = rep;
        return row;
    endfunction

    // Register write on the config channel; the shadow copy follows on the transfer.
    task automatic write_reg(input logic [wbps_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [wbps_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            wbps_pkg::REG_PATTERN_LOW:    sig_lo = val;
            wbps_pkg::REG_PATTERN_HIGH:   sig_hi = val;
            wbps_pkg::REG_CARE_MASK:      sig_care = val[15:0];
            wbps_pkg::REG_PATTERN_LENGTH: sig_len = val[wbps_pkg::LEN_BITS-1:0];
            wbps_pkg::REG_BASE_ADDRESS:   sig_base = val[wbps_pkg::ADDR_BITS-1:0];
            wbps_pkg::REG_FIRST_ONLY:     sig_first_only = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // One byte transfer, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] b, input logic last, input row_kind_t kind,
                             input scan_result_t typed);
        scan_result_t r;
        bit           produces;
        @(negedge aclk);
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data_byte = b;
        s_last_byte = last;
        do @(posedge aclk); while (!s_ready);
        produces = predict_scan(b, last, r);
        if (kind == ROW_FIXED) begin
            append_report(typed);
        end else if (kind == ROW_PREDICT && produces) begin
            append_report(r);
        end
        bytes_sent++;
        if (last) begin
            regions_sent++;
        end
    endtask

    // Stop sending, let every outstanding report arrive, then cover the pipe latency
    // so that bytes without a report are out of the block as well.
    task automatic wait_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // New random register setting; extremes come up often. Upper bits of narrow
    // registers carry junk so that the write masking is exercised.
    task automatic program_random_settings();
        logic [wbps_pkg::CFG_DATA_BITS-1:0] v;
        v = {$urandom, $urandom};
        write_reg(wbps_pkg::REG_PATTERN_LOW, v);
        v = {$urandom, $urandom};
        write_reg(wbps_pkg::REG_PATTERN_HIGH, v);
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v[15:0] = 16'h0000;
            1: v[15:0] = 16'hFFFF;
            default: ;
        endcase
        write_reg(wbps_pkg::REG_CARE_MASK, v);
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v[wbps_pkg::LEN_BITS-1:0] = 5'd0;
            1: v[wbps_pkg::LEN_BITS-1:0] = 5'd1;
            2: v[wbps_pkg::LEN_BITS-1:0] = 5'd16;
            3: v[wbps_pkg::LEN_BITS-1:0] = wbps_pkg::LEN_BITS'($urandom_range(17, 31));
            default: v[wbps_pkg::LEN_BITS-1:0] = wbps_pkg::LEN_BITS'($urandom_range(2, 15));
        endcase
        write_reg(wbps_pkg::REG_PATTERN_LENGTH, v);
        v = {$urandom, $urandom};
        case ($urandom_range(4))
            0: v[wbps_pkg::ADDR_BITS-1:0] = '0;
            1: v[wbps_pkg::ADDR_BITS-1:0] = '1;
            2: v[wbps_pkg::ADDR_BITS-1:0] = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 40));
            default: ;
        endcase
        write_reg(wbps_pkg::REG_BASE_ADDRESS, v);
        write_reg(wbps_pkg::REG_FIRST_ONLY, {$urandom, $urandom});
        if ($urandom_range(3) == 0) begin
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
        end
        settings_used++;
    endtask

    // One region built mostly from planted signatures (wildcard bytes random),
    // with near misses, signature-like bytes and plain noise mixed in.
    task automatic scan_random_region();
        logic [7:0]  region_bytes [$];
        int unsigned target;
        int unsigned n;
        int unsigned k;
        int unsigned start;
        n = active_len();
        target = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 20);
        while (region_bytes.size() < target) begin
            case ($urandom_range(5))
                0, 1, 2: begin
                    start = region_bytes.size();
                    for (k = 0; k < n; k++) begin
                        region_bytes = {region_bytes,
                                        sig_care[k] ? sig_byte(k) : 8'($urandom_range(255))};
                    end
                    // Broken copy: one byte off by a nonzero amount.
                    if ($urandom_range(2) == 0) begin
                        k = start + $urandom_range(n - 1);
                        region_bytes[k] = region_bytes[k] ^ 8'($urandom_range(1, 255));
                    end
                end
                3: region_bytes = {region_bytes, 8'($urandom_range(255))};
                default: region_bytes = {region_bytes, sig_byte($urandom_range(n - 1))};
            endcase
        end
        foreach (region_bytes[i]) begin
            send_byte(region_bytes[i], i == region_bytes.size() - 1, ROW_PREDICT, '0);
        end
    endtask

    // Receiver: ready changes only at the falling edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Report checker: every result transfer is matched against the oldest expectation.
    always @(posedge aclk) begin
        scan_result_t got;
        scan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_match_address, m_hit, m_end_of_scan, m_any_found};
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (want.hit) begin
                    hits_checked++;
                end
                if (got.match_address !== want.match_address) begin
                    $display("%0t: match_address expected %h actual %h",
                             $time, want.match_address, got.match_address);
                    fail_count++;
                end
                if (got.hit !== want.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                    fail_count++;
                end
                if (got.end_of_scan !== want.end_of_scan) begin
                    $display("%0t: end_of_scan expected %b actual %b",
                             $time, want.end_of_scan, got.end_of_scan);
                    fail_count++;
                end
                if (got.any_found !== want.any_found) begin
                    $display("%0t: any_found expected %b actual %b",
                             $time, want.any_found, got.any_found);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned phase_goal;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        s_last_byte = 1'b0;
        fail_count = 0;
        bytes_sent = 0;
        regions_sent = 0;
        reports_checked = 0;
        hits_checked = 0;
        settings_used = 1;
        src_gap_pct = 16;
        sink_stall_pct = 67;

        // Register defaults after reset.
        sig_lo = '0;
        sig_hi = '0;
        sig_care = 16'hFFFF;
        sig_len = 5'd1;
        sig_base = '0;
        sig_first_only = 1'b0;
        clear_region();

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Defaults: one-byte signature 0x00, so a zero byte hits at offset 0 and
        // the region ends with any_found set.
        append_row(byte_row(ROW_FIXED, 8'h00, 1'b0, '{48'h0, 1'b1, 1'b0, 1'b0}));
        append_row(byte_row(ROW_FIXED, 8'hFF, 1'b1, '{48'h0, 1'b0, 1'b1, 1'b1}));
        // Length 0 behaves as 1; base at the top so the second hit wraps to zero,
        // and that hit on the last byte also closes the region. Spare indexes ignored.
        append_row(reg_row(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_00FF));
        append_row(reg_row(wbps_pkg::REG_PATTERN_LENGTH, 64'd0));
        append_row(reg_row(wbps_pkg::REG_BASE_ADDRESS, 64'h0000_FFFF_FFFF_FFFF));
        append_row(reg_row(REG_SPARE_LO, '1));
        append_row(reg_row(REG_SPARE_HI, '1));
        append_row(byte_row(ROW_FIXED, 8'hFF, 1'b0, '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0}));
        append_row(byte_row(ROW_FIXED, 8'hFF, 1'b1, '{48'h0, 1'b1, 1'b1, 1'b1}));
        // Fresh region after the end: found flag is cleared again.
        append_row(byte_row(ROW_FIXED, 8'h00, 1'b1, '{48'h0, 1'b0, 1'b1, 1'b0}));
        // Length above the window size clamps to 16; full window match on the last byte.
        append_row(reg_row(wbps_pkg::REG_PATTERN_LOW, 64'h0706_0504_0302_0100));
        append_row(reg_row(wbps_pkg::REG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908));
        append_row(reg_row(wbps_pkg::REG_PATTERN_LENGTH, 64'd31));
        append_row(reg_row(wbps_pkg::REG_BASE_ADDRESS, 64'h1000));
        append_row(reg_row(wbps_pkg::REG_FIRST_ONLY, 64'd0));
        for (int i = 0; i < 15; i++) begin
            append_row(byte_row(ROW_PREDICT, 8'(i), 1'b0, '0));
        end
        append_row(byte_row(ROW_FIXED, 8'h0F, 1'b1, '{48'h1000, 1'b1, 1'b1, 1'b1}));
        // Length 2 with both care bits clear (higher set bits lie beyond the length):
        // every full window matches, first-only keeps just the first hit.
        append_row(reg_row(wbps_pkg::REG_PATTERN_LENGTH, 64'd2));
        append_row(reg_row(wbps_pkg::REG_CARE_MASK, 64'hFFFC));
        append_row(reg_row(wbps_pkg::REG_FIRST_ONLY, 64'd1));
        append_row(byte_row(ROW_QUIET, 8'hAA, 1'b0, '0));
        append_row(byte_row(ROW_PREDICT, 8'h55, 1'b0, '0));
        append_row(byte_row(ROW_PREDICT, 8'h00, 1'b0, '0));
        append_row(byte_row(ROW_FIXED, 8'hFF, 1'b1, '{48'h0, 1'b0, 1'b1, 1'b1}));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                if (i == 0 || directed_rows[i-1].kind != ROW_REG) begin
                    wait_drain();
                end
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_byte(directed_rows[i].data_byte, directed_rows[i].last_byte,
                          directed_rows[i].kind, directed_rows[i].report);
            end
        end
        settings_used += 3;

        // Random part in three idling modes: slow receiver, slow sender, full rate.
        for (int phase = 0; phase < 3; phase++) begin
            wait_drain();
            case (phase)
                0: begin
                    src_gap_pct = 16;
                    sink_stall_pct = 67;
                end
                1: begin
                    src_gap_pct = 67;
                    sink_stall_pct = 16;
                end
                default: begin
                    src_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            phase_goal = bytes_sent + 400;
            while (bytes_sent < phase_goal) begin
                wait_drain();
                program_random_settings();
                repeat ($urandom_range(2, 6)) begin
                    scan_random_region();
                    // Sender holds off now and then until all reports are in.
                    if ($urandom_range(7) == 0) begin
                        wait_drain();
                    end
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        $display("scanned %0d bytes in %0d regions under %0d register settings",
                 bytes_sent, regions_sent, settings_used);
        $display("checked %0d reports, %0d of them hits, %0d mismatches",
                 reports_checked, hits_checked, fail_count);
        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("wildcard_byte_pattern_scan_top regression: pass");
        end else begin
            $display("wildcard_byte_pattern_scan_top regression: fail");
        end
        $finish;
    end

endmodule

// File: wildcard_byte_pattern_scan_top.f
+incdir+design
design/wbps_pkg.sv
design/wbps_front.sv
design/wbps_queue.sv
design/wbps_back.sv
design/wildcard_byte_pattern_scan_top.sv
verif/testbench.sv
